// File: design/hash_value_histogram_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hash value histogram
// Concurrent assertion wrappers used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef HASH_VALUE_HISTOGRAM_ASSERT_SVH
`define HASH_VALUE_HISTOGRAM_ASSERT_SVH

// Checked at every rising edge, quiet while reset is high.
`define HVH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define HVH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/hvh_pkg.sv
// ---------------------------------------------------------------------------
// hvh_pkg
// Types and constants shared by the controller, the datapath and the checker.
// ---------------------------------------------------------------------------
package hvh_pkg;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int DIST_W   = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;
  localparam int LOG_W    = 5;

  // Fibonacci hashing multiplier and the word width the hash is taken over.
  localparam logic [VALUE_W-1:0] HASH_MUL  = 32'd2654435769;
  localparam logic [5:0]         WORD_BITS = 6'd32;

  // Saturation limits.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  // Table size register lower limit and reset value.
  localparam logic [LOG_W-1:0] LOG_MIN   = 5'd4;
  localparam logic [CFG_W-1:0] LOG_RESET = 4'd10;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FETCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_FETCH,
    S_SCAN,
    S_CLEAR
  } state_t;

  // Kind of result to register.
  typedef enum logic [2:0] {
    RES_INSERT,
    RES_FULL,
    RES_FETCH,
    RES_EXHAUSTED,
    RES_CLEAR
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic probe_start;
    logic probe_next;
    logic ins_write;
    logic fetch_read;
    logic sweep_step;
    logic clear_regs;
    logic res_en;
    res_t res_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_empty;
    logic key_match;
    logic probe_last;
    logic fp_end;
    logic sweep_last;
  } sts_t;

endpackage

// File: design/hvh_ctrl.sv
// ---------------------------------------------------------------------------
// hvh_ctrl
// Sequencer for insert probes, fetch scans and table clearing sweeps.
// ---------------------------------------------------------------------------
module hvh_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hvh_pkg::OP_W-1:0]    op,
  input  hvh_pkg::sts_t               sts,
  output hvh_pkg::cmd_t               cmd,
  output logic                        busy
);

  hvh_pkg::state_t state;
  hvh_pkg::state_t state_next;

  // State register; reset starts a clearing sweep of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hvh_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != hvh_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      hvh_pkg::S_INIT: begin
        if (sts.sweep_last) state_next = hvh_pkg::S_IDLE;
      end
      hvh_pkg::S_IDLE: begin
        if (start) begin
          case (op)
            hvh_pkg::OP_INSERT: state_next = hvh_pkg::S_HASH;
            hvh_pkg::OP_FETCH:  state_next = hvh_pkg::S_FETCH;
            hvh_pkg::OP_CLEAR:  state_next = hvh_pkg::S_CLEAR;
            default:            state_next = hvh_pkg::S_IDLE;
          endcase
        end
      end
      hvh_pkg::S_HASH: begin
        state_next = hvh_pkg::S_PROBE;
      end
      hvh_pkg::S_PROBE: begin
        if (sts.slot_empty || sts.key_match || sts.probe_last) begin
          state_next = hvh_pkg::S_IDLE;
        end
      end
      hvh_pkg::S_FETCH: begin
        state_next = sts.fp_end ? hvh_pkg::S_IDLE : hvh_pkg::S_SCAN;
      end
      hvh_pkg::S_SCAN: begin
        if (!sts.slot_empty || sts.fp_end) state_next = hvh_pkg::S_IDLE;
      end
      hvh_pkg::S_CLEAR: begin
        if (sts.sweep_last) state_next = hvh_pkg::S_IDLE;
      end
      default: state_next = hvh_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.res_kind = hvh_pkg::RES_INSERT;
    case (state)
      hvh_pkg::S_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.clear_regs = sts.sweep_last;
      end
      hvh_pkg::S_IDLE: begin
        cmd.load_item = start;
      end
      hvh_pkg::S_HASH: begin
        cmd.probe_start = 1'b1;
      end
      hvh_pkg::S_PROBE: begin
        if (sts.slot_empty || sts.key_match) begin
          cmd.ins_write = 1'b1;
          cmd.res_en    = 1'b1;
          cmd.res_kind  = hvh_pkg::RES_INSERT;
        end else if (sts.probe_last) begin
          cmd.res_en    = 1'b1;
          cmd.res_kind  = hvh_pkg::RES_FULL;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      hvh_pkg::S_FETCH: begin
        if (sts.fp_end) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = hvh_pkg::RES_EXHAUSTED;
        end else begin
          cmd.fetch_read = 1'b1;
        end
      end
      hvh_pkg::S_SCAN: begin
        if (!sts.slot_empty) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = hvh_pkg::RES_FETCH;
        end else if (sts.fp_end) begin
          cmd.res_en   = 1'b1;
          cmd.res_kind = hvh_pkg::RES_EXHAUSTED;
        end else begin
          cmd.fetch_read = 1'b1;
        end
      end
      hvh_pkg::S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.clear_regs = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_kind   = hvh_pkg::RES_CLEAR;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: design/hvh_datapath.sv
// ---------------------------------------------------------------------------
// hvh_datapath
// Hash unit, slot memory, probe and fetch pointers, and result registers.
// ---------------------------------------------------------------------------
module hvh_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hvh_pkg::cmd_t                    cmd,
  output hvh_pkg::sts_t                    sts,
  input  logic                             cfg_write,
  input  logic [hvh_pkg::CFG_W-1:0]        cfg_data,
  input  logic [hvh_pkg::VALUE_W-1:0]      value,
  output logic                             done,
  output logic [hvh_pkg::COUNT_W-1:0]      count,
  output logic [hvh_pkg::DIST_W-1:0]       distinct,
  output logic [hvh_pkg::STATUS_W-1:0]     status
);

  // Largest power of two not above the depth sets the slot index width.
  localparam int AW        = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int FW        = AW + 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int ROW_W     = hvh_pkg::VALUE_W + hvh_pkg::COUNT_W;

  // Slot memory: key in the upper half, count in the lower half.
  logic [ROW_W-1:0] mem [MEM_DEPTH];
  logic [ROW_W-1:0] rdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [ROW_W-1:0] wdata;
  logic             we;

  // Control and working registers.
  logic [hvh_pkg::CFG_W-1:0]   lg;
  logic [hvh_pkg::VALUE_W-1:0] key;
  logic [hvh_pkg::VALUE_W-1:0] prod;
  logic [AW-1:0]               idx;
  logic [AW-1:0]               tries;
  logic [FW-1:0]               fp;
  logic [hvh_pkg::DIST_W-1:0]  distinct_total;

  // Derived values.
  logic [hvh_pkg::LOG_W-1:0]   lg_eff;
  logic [hvh_pkg::LOG_W-1:0]   lg_ext;
  logic [AW-1:0]               mask;
  logic [FW-1:0]               slots;
  logic [hvh_pkg::VALUE_W-1:0] home_wide;
  logic [AW-1:0]               home;
  logic [AW-1:0]               next_idx;
  logic [hvh_pkg::COUNT_W-1:0] rcount;
  logic [hvh_pkg::VALUE_W-1:0] rkey;
  logic [hvh_pkg::COUNT_W-1:0] new_count;
  logic [hvh_pkg::DIST_W-1:0]  dist_inc;

  // Clamp the size register to the range the table supports.
  always_comb begin
    lg_ext = {1'b0, lg};
    if (lg_ext < hvh_pkg::LOG_MIN) begin
      lg_eff = hvh_pkg::LOG_MIN;
    end else if (lg_ext > hvh_pkg::LOG_W'(AW)) begin
      lg_eff = hvh_pkg::LOG_W'(AW);
    end else begin
      lg_eff = lg_ext;
    end
  end

  assign mask  = {AW{1'b1}} >> (hvh_pkg::LOG_W'(AW) - lg_eff);
  assign slots = {1'b0, mask} + FW'(1);

  // Home slot is the top bits of the hashed value.
  assign home_wide = prod >> (hvh_pkg::WORD_BITS - {1'b0, lg_eff});
  assign home      = home_wide[AW-1:0];
  assign next_idx  = (idx + AW'(1)) & mask;

  assign rcount = rdata[hvh_pkg::COUNT_W-1:0];
  assign rkey   = rdata[ROW_W-1:hvh_pkg::COUNT_W];

  // New count for an insert: one in an empty slot, else one more, saturating at the maximum.
  always_comb begin
    if (rcount == '0) begin
      new_count = hvh_pkg::COUNT_W'(1);
    end else if (rcount == hvh_pkg::COUNT_MAX) begin
      new_count = rcount;
    end else begin
      new_count = rcount + hvh_pkg::COUNT_W'(1);
    end
  end

  assign dist_inc = (distinct_total == hvh_pkg::DIST_MAX) ? distinct_total
                                                          : distinct_total + hvh_pkg::DIST_W'(1);

  // Status to the controller.
  assign sts.slot_empty = (rcount == '0);
  assign sts.key_match  = (rkey == key);
  assign sts.probe_last = (tries == mask);
  assign sts.fp_end     = (fp >= slots);
  assign sts.sweep_last = (&idx);

  // Memory address and write data selection.
  always_comb begin
    if (cmd.probe_start) begin
      raddr = home;
    end else if (cmd.probe_next) begin
      raddr = next_idx;
    end else begin
      raddr = fp[AW-1:0];
    end
    waddr = idx;
    we    = cmd.sweep_step || cmd.ins_write;
    if (cmd.ins_write) begin
      wdata = {key, new_count};
    end else begin
      wdata = '0;
    end
  end

  // Slot memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Hash register and item key.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key  <= value;
      prod <= value * hvh_pkg::HASH_MUL;
    end
  end

  // Pointers, totals and the size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lg             <= hvh_pkg::LOG_RESET;
      idx            <= '0;
      tries          <= '0;
      fp             <= '0;
      distinct_total <= '0;
      done           <= 1'b0;
    end else begin
      done <= cmd.res_en;
      if (cfg_write) begin
        lg <= cfg_data;
      end
      if (cmd.load_item) begin
        idx <= '0;
      end
      if (cmd.probe_start) begin
        idx   <= home;
        tries <= '0;
      end
      if (cmd.probe_next) begin
        idx   <= next_idx;
        tries <= tries + AW'(1);
      end
      if (cmd.sweep_step) begin
        idx <= idx + AW'(1);
      end
      if (cmd.fetch_read) begin
        fp <= fp + FW'(1);
      end
      if (cmd.ins_write && sts.slot_empty) begin
        distinct_total <= dist_inc;
      end
      if (cmd.clear_regs) begin
        distinct_total <= '0;
        fp             <= '0;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      case (cmd.res_kind)
        hvh_pkg::RES_INSERT: begin
          count    <= new_count;
          distinct <= sts.slot_empty ? dist_inc : distinct_total;
          status   <= hvh_pkg::ST_OK;
        end
        hvh_pkg::RES_FULL: begin
          count    <= '0;
          distinct <= distinct_total;
          status   <= hvh_pkg::ST_FULL;
        end
        hvh_pkg::RES_FETCH: begin
          count    <= rcount;
          distinct <= distinct_total;
          status   <= hvh_pkg::ST_OK;
        end
        hvh_pkg::RES_EXHAUSTED: begin
          count    <= '0;
          distinct <= distinct_total;
          status   <= hvh_pkg::ST_EXHAUSTED;
        end
        default: begin
          count    <= '0;
          distinct <= '0;
          status   <= hvh_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

// File: design/hash_value_histogram.sv
// Insert: the hash is registered, then slots are probed from the home slot, one per cycle.
// Fetch: slots are scanned in table order, one per cycle through the slot memory port.
// Clear: all 2^floor(log2(TABLE_DEPTH)) slots are zeroed, one slot written per cycle.
// After reset, busy stays high while the counts of all 2^floor(log2(TABLE_DEPTH)) slots (1024
// by default) are cleared; the size register may be written during that time.
// One item is in work at a time; the next is taken in the done cycle; results cannot stall.
// ---------------------------------------------------------------------------
// hash_value_histogram
// Counts occurrences of 32-bit values in an open-addressing hash table with
// linear probing, and fetches the nonzero counts in table order.
// ---------------------------------------------------------------------------
module hash_value_histogram #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hvh_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [hvh_pkg::OP_W-1:0]      op,
  input  logic [hvh_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [hvh_pkg::COUNT_W-1:0]   count,
  output logic [hvh_pkg::DIST_W-1:0]    distinct,
  output logic [hvh_pkg::STATUS_W-1:0]  status
);

  hvh_pkg::cmd_t cmd;
  hvh_pkg::sts_t sts;

  // Sequencer.
  hvh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table and arithmetic.
  hvh_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .value     (value),
    .done      (done),
    .count     (count),
    .distinct  (distinct),
    .status    (status)
  );

endmodule

// File: design/hvh_checker.sv
// ---------------------------------------------------------------------------
// hvh_checker
// Port-level checks on the hash value histogram, bound to the top level.
// ---------------------------------------------------------------------------
`include "hash_value_histogram_assert.svh"

module hvh_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [hvh_pkg::OP_W-1:0]      op,
  input logic                          done,
  input logic [hvh_pkg::COUNT_W-1:0]   count,
  input logic [hvh_pkg::STATUS_W-1:0]  status
);

  // A result only follows a cycle in which the block was working.
  `HVH_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "result without work")

  // An accepted operation other than OP_NONE keeps the block busy in the next cycle.
  `HVH_ASSERT(a_accept_busy, clk, rst, start && !busy && op != hvh_pkg::OP_NONE |=> busy, "item accepted but block not busy")

  // Dropped keys and exhausted fetches report a zero count.
  `HVH_ASSERT(a_fail_zero, clk, rst, done && (status == hvh_pkg::ST_FULL || status == hvh_pkg::ST_EXHAUSTED) |-> count == '0, "nonzero count on failure")

  // Leaving reset starts the clearing sweep.
  `HVH_ASSERT_ALWAYS(a_reset_sweep, clk, $fell(rst) |-> busy, "no clearing sweep after reset")

endmodule

bind hash_value_histogram hvh_checker u_checker (.*);
